// ===== design/lcas_pkg.sv =====
package lcas_pkg;

   // grid limits
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int DIM_W    = 11;

   localparam logic [DIM_W-1:0] ROWS_MAX   = DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0] COLS_MAX   = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(8);

   // register indexes (byte address bit 2)
   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   // input item kinds
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic next_alive;
      logic frame_last;
   } lcas_result_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [1:0]       data;
   } lcas_wr_type;

endpackage

// ===== design/life_cellular_automaton_step_core.sv =====
// Results: a cell's next state is registered by the output buffer on the beat that
//   completes its window, which is grid_cols+1 input beats after the cell itself.
// Throughput: one beat per cycle while skid is free; set by the simple dual-port
//   line store (read + write per cycle, next-column read-ahead, write forwarding).
// Reset: synchronous, active high; grid_rows = grid_cols = 8, counters and window
//   cleared, line store contents left as they are (masked by the row counters).
module life_cellular_automaton_step_core
   import lcas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input cells
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_cell_alive,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_next_alive,
   output logic        rsp_frame_last,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [DIM_W-1:0] grid_rows_ff, grid_rows_in;
   logic [DIM_W-1:0] grid_cols_ff, grid_cols_in;
   logic [DIM_W-1:0] wr_val, rows_val, cols_val;
   logic             csr_wr, beat, res_valid;
   logic [COL_W-1:0] rd_addr;
   logic [1:0]       stored;
   lcas_wr_type      ram_wr;
   lcas_result_type  res, rsp_data;

   // --- register port -------------------------------------------------------
   // Sizes are clamped on write: zero becomes one, anything above the grid
   // limit becomes the limit. Any write restarts the frame.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign wr_val     = csr_pwdata[DIM_W-1:0];

   always_comb begin
      rows_val = (wr_val == '0) ? DIM_W'(1) : ((wr_val > ROWS_MAX) ? ROWS_MAX : wr_val);
      cols_val = (wr_val == '0) ? DIM_W'(1) : ((wr_val > COLS_MAX) ? COLS_MAX : wr_val);
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_GRID_ROWS: grid_rows_in = rows_val;
            REG_GRID_COLS: grid_cols_in = cols_val;
            default:       grid_rows_in = grid_rows_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_GRID_ROWS: csr_prdata = {{(32-DIM_W){1'b0}}, grid_rows_ff};
         REG_GRID_COLS: csr_prdata = {{(32-DIM_W){1'b0}}, grid_cols_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_RESET;
         grid_cols_ff <= DIM_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   // --- datapath ------------------------------------------------------------
   // A beat is taken whenever the skid stage is free; the result (if any) goes
   // straight to the output register or, when that is stalled, to the skid.
   assign beat = req_valid && req_ready;

   lcas_line_ram u_line_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (stored)
   );

   lcas_step_ctrl u_step_ctrl (
      .clock      (clock),
      .reset      (reset),
      .grid_rows  (grid_rows_ff),
      .grid_cols  (grid_cols_ff),
      .restart    (csr_wr),
      .beat       (beat),
      .kind       (req_kind),
      .cell_alive (req_cell_alive),
      .stored     (stored),
      .rd_addr    (rd_addr),
      .wr         (ram_wr),
      .res_valid  (res_valid),
      .res        (res)
   );

   lcas_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ready)
   );

   assign rsp_next_alive = rsp_data.next_alive;
   assign rsp_frame_last = rsp_data.frame_last;

endmodule

// ===== design/lcas_line_ram.sv =====
module lcas_line_ram
   import lcas_pkg::*;
(
   input  logic             clock,
   input  lcas_wr_type      wr,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data
);

   logic [1:0] mem [MAX_COLS];
   logic [1:0] rd_data_ff;

   // write-first: a read of the entry being written sees the new value
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lcas_step_ctrl.sv =====
module lcas_step_ctrl
   import lcas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] grid_rows,
   input  logic [DIM_W-1:0] grid_cols,
   input  logic             restart,
   input  logic             beat,
   input  logic             kind,
   input  logic             cell_alive,
   input  logic [1:0]       stored,
   output logic [COL_W-1:0] rd_addr,
   output lcas_wr_type      wr,
   output logic             res_valid,
   output lcas_result_type  res
);

   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [8:0]       window_ff, window_in;

   logic             bot, mid, top, col_first, have, last, in_wrap, out_wrap;
   logic [2:0]       triple;
   logic [8:0]       win;
   logic [3:0]       cnt;
   logic [DIM_W:0]   rows_p1;

   always_comb begin
      rows_p1   = {1'b0, grid_rows} + (DIM_W+1)'(1);
      bot       = (kind == KIND_CELL) && (in_row_ff < grid_rows) && cell_alive;
      mid       = (in_row_ff != '0) && (in_row_ff <= grid_rows) && stored[0];
      top       = (in_row_ff >= DIM_W'(2)) && ({1'b0, in_row_ff} <= rows_p1) && stored[1];
      triple    = {top, mid, bot};
      col_first = (in_col_ff == '0);

      if (col_first) begin
         win       = {window_ff[5:0], 3'b000};
         window_in = {6'b0, triple};
         have      = (in_row_ff >= DIM_W'(2));
      end else begin
         win       = {window_ff[5:0], triple};
         window_in = win;
         have      = (in_row_ff != '0);
      end

      cnt = 4'(win[0]) + 4'(win[1]) + 4'(win[2]) + 4'(win[3])
          + 4'(win[5]) + 4'(win[6]) + 4'(win[7]) + 4'(win[8]);
      res.next_alive = (cnt == 4'd3) || (win[4] && (cnt == 4'd2));

      out_wrap       = ({1'b0, out_col_ff} + DIM_W'(1)) >= grid_cols;
      last           = (({1'b0, out_row_ff} + DIM_W'(1)) >= grid_rows) && out_wrap;
      res.frame_last = last;
      res_valid      = beat && have;

      in_wrap = ({1'b0, in_col_ff} + DIM_W'(1)) >= grid_cols;

      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;

      if (restart || reset || (beat && have && last)) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         window_in  = '0;
      end else if (beat) begin
         if (have) begin
            if (out_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end else begin
         window_in = window_ff;
      end
   end

   // line store: read ahead for the next beat's column, write back this one
   assign rd_addr = in_col_in;
   assign wr.en   = beat;
   assign wr.addr = in_col_ff;
   assign wr.data = {mid, bot};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         window_ff  <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         window_ff  <= window_in;
      end
   end

endmodule

// ===== design/lcas_out_buf.sv =====
module lcas_out_buf
   import lcas_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  lcas_result_type in_data,
   output logic            in_ready,
   output logic            out_valid,
   output lcas_result_type out_data,
   input  logic            out_ready
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   lcas_result_type out_data_ff, out_data_in;
   lcas_result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = in_valid;
            out_data_in   = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== tb/tb_life_cellular_automaton_step_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the streaming Life (B3/S23) step core.
// Cells go in one beat at a time in raster order, the bench keeps its own
// line store and 3x3 window and queues the next state it expects for every
// beat that completes a window. Each result beat is matched against the
// head of that queue.
module tb_life_cellular_automaton_step_core;
   import lcas_pkg::*;

   localparam int SETTLE_CYCLES = 8;    // idle pad once every expected result is back
   localparam int FRAME_CLEAN   = 0;    // R*C cells then C+1 flush beats
   localparam int FRAME_NOISY   = 1;    // kinds flipped at random
   localparam int FRAME_CUT     = 2;    // frame broken off part way
   localparam int PHASE_BEATS   = 80;   // random beats per idling profile

   // ------------------------------------------------------------------
   // Clock, reset and every DUT input at a known value from time zero
   // ------------------------------------------------------------------
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_kind       = KIND_CELL;
   logic        req_cell_alive = 1'b0;
   logic        rsp_ready      = 1'b0;
   logic        csr_psel       = 1'b0;
   logic        csr_penable    = 1'b0;
   logic        csr_pwrite     = 1'b0;
   logic [2:0]  csr_paddr      = '0;
   logic [31:0] csr_pwdata     = '0;

   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_next_alive;
   logic        rsp_frame_last;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #4 clock = ~clock;

   life_cellular_automaton_step_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_cell_alive (req_cell_alive),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_alive (rsp_next_alive),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // ------------------------------------------------------------------
   // Bench-side copy of the grid state
   // ------------------------------------------------------------------
   logic [1:0]      prev_rows [MAX_COLS];  // bit0 = row above, bit1 = two rows above
   logic [8:0]      nbhd;                  // three column triples, newest in [2:0]
   int unsigned     cur_row, cur_col;      // position of the next incoming beat
   int unsigned     res_row, res_col;      // position of the next result
   int unsigned     rows_cfg, cols_cfg;

   lcas_result_type expected_states [$];

   int unsigned     req_idle_pct = 31;
   int unsigned     rsp_idle_pct = 55;
   int unsigned     beats_sent, results_checked, reg_writes, mismatches, frames_flagged;

   function automatic void restart_grid();
      nbhd    = '0;
      cur_row = 0;
      cur_col = 0;
      res_row = 0;
      res_col = 0;
   endfunction

   // only the low 11 bits count; zero reads as one, too big reads as the maximum
   function automatic int unsigned clamp_dim(logic [31:0] value, int unsigned ceiling);
      int unsigned v;
      v = 32'(value[DIM_W-1:0]);
      if (v == 0)
         return 1;
      if (v > ceiling)
         return ceiling;
      return v;
   endfunction

   function automatic void write_grid_reg(logic idx, logic [31:0] value);
      if (idx == REG_GRID_ROWS)
         rows_cfg = clamp_dim(value, MAX_ROWS);
      else
         cols_cfg = clamp_dim(value, MAX_COLS);
      restart_grid();
   endfunction

   function automatic bit row_in_grid(int unsigned r, int unsigned back);
      return (r >= back) && ((r - back) < rows_cfg);
   endfunction

   // Advance the grid by one accepted beat, queueing the next state it yields.
   function automatic void predict_beat(logic kind, logic alive);
      int unsigned     col;
      logic [1:0]      kept;
      logic            bot, mid, top;
      logic [8:0]      win;
      bit              have;
      int unsigned     nsum;
      lcas_result_type res;

      col  = (cur_col < MAX_COLS) ? cur_col : MAX_COLS - 1;
      kept = prev_rows[col];
      // flush beats and beats past the last row feed dead cells
      bot  = (kind == KIND_CELL && row_in_grid(cur_row, 0)) ? alive : 1'b0;
      mid  = row_in_grid(cur_row, 1) ? kept[0] : 1'b0;
      top  = row_in_grid(cur_row, 2) ? kept[1] : 1'b0;
      prev_rows[col] = {mid, bot};

      if (cur_col != 0) begin
         win  = {nbhd[5:0], top, mid, bot};
         have = (cur_row >= 1);
         nbhd = win;
      end else begin
         // column zero closes the previous row's last window with a dead edge
         win  = {nbhd[5:0], 3'b000};
         have = (cur_row >= 2);
         nbhd = {6'b0, top, mid, bot};
      end

      if (have) begin
         nsum           = $countones(win) - win[4];
         res.next_alive = (nsum == 3) || (win[4] && nsum == 2);
         res.frame_last = (res_row + 1 >= rows_cfg) && (res_col + 1 >= cols_cfg);
         expected_states.push_back(res);
         if (res.frame_last) begin
            restart_grid();
            return;
         end
         res_col++;
         if (res_col >= cols_cfg) begin
            res_col = 0;
            res_row++;
         end
      end

      cur_col++;
      if (cur_col >= cols_cfg) begin
         cur_col = 0;
         cur_row++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : check_results
      lcas_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result beat with nothing expected: next_alive=%0b frame_last=%0b",
                        $realtime, rsp_next_alive, rsp_frame_last);
         end else begin
            want = expected_states.pop_front();
            if (rsp_next_alive !== want.next_alive || rsp_frame_last !== want.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result %0d: expected next_alive=%0b frame_last=%0b, got %0b %0b",
                           $realtime, results_checked, want.next_alive, want.frame_last,
                           rsp_next_alive, rsp_frame_last);
            end
            if (want.frame_last)
               frames_flagged++;
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------
   // One cell beat: optional idle gap, then hold valid until taken.
   task automatic send_beat(input logic kind, input logic alive);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_cell_alive <= alive;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_beat(kind, alive);
      beats_sent++;
   endtask

   // Let the block go quiet: all results back, then the SETTLE_CYCLES pad, since
   // beats early in a frame leave nothing to wait for.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup then access phase; the register lands on the edge with penable high.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      write_grid_reg(idx, value);
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic run_frame(input int unsigned style);
      int unsigned cells, span, density, k;
      logic        kind;
      cells   = rows_cfg * cols_cfg;
      span    = cells + cols_cfg + 1;
      density = $urandom_range(5, 95);
      if (style == FRAME_CUT)
         span = $urandom_range(1, span - 1);
      for (k = 0; k < span; k++) begin
         kind = (k < cells) ? KIND_CELL : KIND_FLUSH;
         // early flush reads as a dead cell, a late cell as a flush
         if (style == FRAME_NOISY && $urandom_range(99) < 15)
            kind = ~kind;
         send_beat(kind, $urandom_range(99) < density);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset size of 8x8 with random content, no register write beforehand.
   task automatic test_reset_size();
      run_frame(FRAME_CLEAN);
      wait_idle();
   endtask

   // Vertical blinker on 3x3 turns horizontal; flush beats carry alive=1.
   task automatic test_blinker();
      logic [8:0] pattern;
      int         k;
      pattern = 9'b010_010_010;
      csr_write(REG_GRID_ROWS, 32'd3);
      csr_write(REG_GRID_COLS, 32'd3);
      for (k = 8; k >= 0; k--)
         send_beat(KIND_CELL, pattern[k]);
      repeat (4) send_beat(KIND_FLUSH, 1'b1);
      wait_idle();
   endtask

   // 2x2: early flush, cells past the frame end, then a write mid-frame.
   task automatic test_frame_edges();
      csr_write(REG_GRID_ROWS, 32'd2);
      csr_write(REG_GRID_COLS, 32'd2);
      send_beat(KIND_CELL,  1'b1);
      send_beat(KIND_FLUSH, 1'b1);
      send_beat(KIND_CELL,  1'b1);
      send_beat(KIND_CELL,  1'b1);
      repeat (3) send_beat(KIND_CELL, 1'b1);
      // next frame starts here, broken off after two beats
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_CELL, 1'b0);
      wait_idle();
      csr_write(REG_GRID_COLS, 32'd2);
      run_frame(FRAME_CLEAN);
      wait_idle();
   endtask

   // Out-of-range sizes: zero, bits above the field, and above the maximum.
   task automatic test_size_clamping();
      csr_write(REG_GRID_ROWS, 32'd0);
      csr_write(REG_GRID_COLS, 32'h0000_0800);
      run_frame(FRAME_CLEAN);
      wait_idle();
      csr_write(REG_GRID_COLS, 32'hFFFF_F805);
      run_frame(FRAME_CLEAN);
      wait_idle();
      csr_write(REG_GRID_ROWS, 32'd2047);
      csr_write(REG_GRID_COLS, 32'd1);
      run_frame(FRAME_CLEAN);
      wait_idle();
   endtask

   function automatic logic [31:0] pick_dim();
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(99);
      if (r < 5)
         v = 32'd0;
      else if (r < 15)
         v = 32'd1;
      else if (r < 22)
         v = $urandom_range(9, 24);
      else
         v = $urandom_range(2, 8);
      // occasional junk above the 11-bit field
      if ($urandom_range(99) < 20)
         v[31:DIM_W] = (32-DIM_W)'($urandom);
      return v;
   endfunction

   // Mostly clean frames of random content, some noisy ones and some cut short.
   task automatic test_random_frames();
      int unsigned start, pick, style;
      bit          resize;
      start  = beats_sent;
      resize = 1'b0;
      while (beats_sent - start < PHASE_BEATS) begin
         if (resize || $urandom_range(99) < 40) begin
            wait_idle();
            pick = $urandom_range(2);
            if (pick != 2)
               csr_write(REG_GRID_ROWS, pick_dim());
            if (pick != 1)
               csr_write(REG_GRID_COLS, pick_dim());
         end
         pick   = $urandom_range(99);
         style  = (pick < 75) ? FRAME_CLEAN : (pick < 88) ? FRAME_NOISY : FRAME_CUT;
         resize = (style == FRAME_CUT);
         run_frame(style);
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < MAX_COLS; i++)
         prev_rows[i] = '0;
      rows_cfg = 8;
      cols_cfg = 8;
      restart_grid();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles more lightly than the receiver first
      test_reset_size();
      test_blinker();
      test_frame_edges();
      test_random_frames();

      // swap the idling sides
      req_idle_pct = 55;
      rsp_idle_pct = 31;
      test_random_frames();

      // flat out, including the big clamped grid
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_size_clamping();
      test_random_frames();

      wait_idle();

      $display("Run covered %0d cell beats, %0d next states, %0d flagged frame ends,",
               beats_sent, results_checked, frames_flagged);
      $display("%0d size writes including clamped ones, grids 1x1 up to 1024x1",
               reg_writes);
      if (mismatches == 0 && expected_states.size() == 0) begin
         $display("life_cellular_automaton_step_core verification clean");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatches, expected_states.size());
         $display("life_cellular_automaton_step_core verification failed");
      end
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_states.size());
      $display("life_cellular_automaton_step_core verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/lcas_pkg.sv
design/lcas_line_ram.sv
design/lcas_step_ctrl.sv
design/lcas_out_buf.sv
design/life_cellular_automaton_step_core.sv
tb/tb_life_cellular_automaton_step_core.sv
